>>> hdl/tdf_pkg.sv
// ---------------------------------------------------------------------------
// tdf_pkg
// Shared types, constants and helpers of the TLV8 fragment deframer.
// ---------------------------------------------------------------------------
package tdf_pkg;

	localparam int LEN_BITS = 16;
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
	localparam logic [7:0] FULL_CHUNK = 8'd255;
	localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

	typedef logic [LEN_BITS-1:0] len_t;

	typedef enum logic [1:0] {
		KIND_VALUE = 2'd0,
		KIND_END   = 2'd1,
		KIND_TRUNC = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  item_type;
		logic [7:0]  value_byte;
		logic [15:0] item_length;
		logic        last_of_run;
	} result_t;

	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [15:0] len_out(len_t l);
		logic [LEN_BITS+15:0] w;
		w = {16'd0, l};
		if (w[LEN_BITS+15:16] != '0)
			return 16'hFFFF;
		return w[15:0];
	endfunction

	function automatic result_t mk_res(kind_t k, logic [7:0] t, logic [7:0] v, len_t l);
		result_t r;
		r.kind        = k;
		r.item_type   = t;
		r.value_byte  = v;
		r.item_length = len_out(l);
		r.last_of_run = 1'b0;
		return r;
	endfunction

endpackage

>>> hdl/tdf_stream_if.sv
// ---------------------------------------------------------------------------
// tdf_stream_if
// Byte stream channel into the deframer.
// ---------------------------------------------------------------------------
interface tdf_stream_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;
	logic       end_of_buffer;

	modport source (output valid, output stream_byte, output end_of_buffer, input ready);
	modport sink (input valid, input stream_byte, input end_of_buffer, output ready);
endinterface

>>> hdl/tdf_result_if.sv
// ---------------------------------------------------------------------------
// tdf_result_if
// Result channel out of the deframer.
// ---------------------------------------------------------------------------
interface tdf_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  item_type;
	logic [7:0]  value_byte;
	logic [15:0] item_length;
	logic        last_of_run;

	modport source (output valid, output kind, output item_type, output value_byte,
		output item_length, output last_of_run, input ready);
	modport sink (input valid, input kind, input item_type, input value_byte,
		input item_length, input last_of_run, output ready);
endinterface

>>> hdl/tdf_front.sv
// ---------------------------------------------------------------------------
// tdf_front
// Parser: accepts stream beats, tracks the record phase and pushes the one
// or two results of a byte, if it has any, into the queue as a single entry.
// ---------------------------------------------------------------------------
module tdf_front
	import tdf_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	tdf_stream_if.sink     stream,
	input  q_stat_t        q_stat,
	output logic           push,
	output entry_t         push_entry
);

	typedef enum logic [2:0] {
		PH_TYPE = 3'b001,
		PH_LEN  = 3'b010,
		PH_VAL  = 3'b100
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] type_q, type_d;
	logic [7:0] chunk_q, chunk_d;
	len_t       mlen_q, mlen_d;
	logic       open_q, open_d;
	logic       full_q, full_d;

	logic       acc;
	logic [1:0] cnt;
	logic [7:0] b;
	logic       eob;
	len_t       mlen_inc;
	logic [7:0] chunk_dec;

	assign stream.ready = !q_stat.full;
	assign acc = stream.valid && stream.ready;
	assign b = stream.stream_byte;
	assign eob = stream.end_of_buffer;
	assign mlen_inc = (mlen_q != LEN_MAX) ? mlen_q + len_t'(1) : mlen_q;
	assign chunk_dec = chunk_q - 8'd1;

	always_comb begin
		phase_d = phase_q;
		type_d = type_q;
		chunk_d = chunk_q;
		mlen_d = mlen_q;
		open_d = open_q;
		full_d = full_q;
		cnt = 2'd0;
		push_entry = '0;
		unique case (phase_q)
			PH_LEN: begin
				if (b == 8'd0) begin
					push_entry.r0 = mk_res(KIND_END, type_q, 8'd0, mlen_q);
					cnt = 2'd1;
					open_d = 1'b0;
					full_d = 1'b0;
					phase_d = PH_TYPE;
				end else begin
					chunk_d = b;
					full_d = (b == FULL_CHUNK);
					phase_d = PH_VAL;
					if (eob) begin
						push_entry.r0 = mk_res(KIND_TRUNC, type_q, 8'd0, mlen_q);
						cnt = 2'd1;
					end
				end
			end
			PH_VAL: begin
				mlen_d = mlen_inc;
				chunk_d = chunk_dec;
				push_entry.r0 = mk_res(KIND_VALUE, type_q, b, mlen_inc);
				cnt = 2'd1;
				phase_d = (chunk_dec == 8'd0) ? PH_TYPE : PH_VAL;
				if (chunk_dec == 8'd0) begin
					if (!(full_q && !eob)) begin
						push_entry.r1 = mk_res(KIND_END, type_q, 8'd0, mlen_inc);
						cnt = 2'd2;
						open_d = 1'b0;
						full_d = 1'b0;
					end
				end else if (eob) begin
					push_entry.r1 = mk_res(KIND_TRUNC, type_q, 8'd0, mlen_inc);
					cnt = 2'd2;
				end
			end
			default: begin
				phase_d = PH_LEN;
				if (open_q && full_q && b == type_q) begin
					full_d = 1'b0;
					if (eob) begin
						push_entry.r0 = mk_res(KIND_TRUNC, type_q, 8'd0, mlen_q);
						cnt = 2'd1;
					end
				end else begin
					type_d = b;
					mlen_d = '0;
					open_d = 1'b1;
					full_d = 1'b0;
					if (open_q) begin
						push_entry.r0 = mk_res(KIND_END, type_q, 8'd0, mlen_q);
						cnt = 2'd1;
						if (eob) begin
							push_entry.r1 = mk_res(KIND_TRUNC, b, 8'd0, '0);
							cnt = 2'd2;
						end
					end else if (eob) begin
						push_entry.r0 = mk_res(KIND_TRUNC, b, 8'd0, '0);
						cnt = 2'd1;
					end
				end
			end
		endcase
		if (eob) begin
			phase_d = PH_TYPE;
			type_d = '0;
			chunk_d = '0;
			mlen_d = '0;
			open_d = 1'b0;
			full_d = 1'b0;
		end
		push_entry.two = (cnt == 2'd2);
	end

	assign push = acc && (cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			type_q <= '0;
			chunk_q <= '0;
			mlen_q <= '0;
			open_q <= 1'b0;
			full_q <= 1'b0;
		end else if (acc) begin
			phase_q <= phase_d;
			type_q <= type_d;
			chunk_q <= chunk_d;
			mlen_q <= mlen_d;
			open_q <= open_d;
			full_q <= full_d;
		end
	end

endmodule

>>> hdl/tdf_queue.sv
// ---------------------------------------------------------------------------
// tdf_queue
// Short entry queue between parser and output stage.
// ---------------------------------------------------------------------------
module tdf_queue
	import tdf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  entry_t  push_entry,
	input  logic    pop,
	output entry_t  head,
	output q_stat_t q_stat
);

	entry_t                mem_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0] wr_q;
	logic [Q_PTR_BITS-1:0] rd_q;
	logic [Q_PTR_BITS:0]   cnt_q;
	logic                  do_push;
	logic                  do_pop;

	assign q_stat.full = (cnt_q == (Q_PTR_BITS+1)'(Q_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign do_push = push && !q_stat.full;
	assign do_pop = pop && !q_stat.empty;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + Q_PTR_BITS'(1);
			if (do_pop)
				rd_q <= rd_q + Q_PTR_BITS'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + (Q_PTR_BITS+1)'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - (Q_PTR_BITS+1)'(1);
		end
	end

endmodule

>>> hdl/tdf_back.sv
// ---------------------------------------------------------------------------
// tdf_back
// Output stage: splits each queue entry into its result beats and holds
// them in an output register until the receiver takes them.
// ---------------------------------------------------------------------------
module tdf_back
	import tdf_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  entry_t        head,
	input  q_stat_t       q_stat,
	output logic          pop,
	tdf_result_if.source  result
);

	logic    sub_q;
	logic    valid_q;
	result_t data_q;
	result_t pick;
	logic    load;
	logic    last;

	assign load = !q_stat.empty && (!valid_q || result.ready);
	assign last = sub_q || !head.two;
	assign pop = load && last;

	always_comb begin
		pick = sub_q ? head.r1 : head.r0;
		pick.last_of_run = last;
	end

	always_ff @(posedge clk) begin
		if (load)
			data_q <= pick;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				sub_q <= !last;
				valid_q <= 1'b1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign result.valid = valid_q;
	assign result.kind = data_q.kind;
	assign result.item_type = data_q.item_type;
	assign result.value_byte = data_q.value_byte;
	assign result.item_length = data_q.item_length;
	assign result.last_of_run = data_q.last_of_run;

endmodule

>>> hdl/tlv8_fragment_deframer_unit.sv
// ---------------------------------------------------------------------------
// tlv8_fragment_deframer_unit
// TLV8 byte stream deframer with reassembly of 255-byte fragments.
//
// stream: one buffer byte per beat, end_of_buffer marks its last byte.
// result: value bytes tagged with the item type, item ends with the merged
//   length (saturated at 65535), and truncated-stream errors; last_of_run
//   marks the final result of one input byte.
// Results pass through the queue and then the output register before they
//   reach the result channel; a byte's second result follows its first.
// Throughput: one byte per cycle until the queue fills, one result beat per
//   cycle while the receiver is ready, set by the single output register.
// A four-entry queue parts parser and output register; when the receiver
//   stalls, the queue fills and stream.ready drops until an entry drains.
// Reset clears parser state, queue and output valid; after a byte marked
//   end_of_buffer the parser returns to its reset state by itself.
// ---------------------------------------------------------------------------
module tlv8_fragment_deframer_unit
	import tdf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	tdf_stream_if.sink   stream,
	tdf_result_if.source result
);

	logic    push;
	logic    pop;
	entry_t  push_entry;
	entry_t  head;
	q_stat_t q_stat;

	tdf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (stream),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	tdf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	tdf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.result (result)
	);

endmodule
